[rtl/core/hrhp_pkg.sv]
package hrhp_pkg;

    localparam int unsigned CountWidth = 5;

    typedef logic [7:0] byte_t;
    typedef logic [CountWidth-1:0] count_t;

    typedef enum logic [3:0] {
        PH_METHOD   = 4'd0,
        PH_PATH     = 4'd1,
        PH_SKIPLINE = 4'd2,
        PH_LINE     = 4'd3,
        PH_NAME     = 4'd4,
        PH_SKIPONE  = 4'd5,
        PH_VALUE    = 4'd6,
        PH_SKIPLF   = 4'd7,
        PH_DONE     = 4'd8
    } phase_t;

    typedef logic [2:0] kind_t;

    localparam kind_t KIND_METHOD = 3'd0;
    localparam kind_t KIND_PATH   = 3'd1;
    localparam kind_t KIND_NAME   = 3'd2;
    localparam kind_t KIND_VALUE  = 3'd3;
    localparam kind_t KIND_END    = 3'd4;

    localparam byte_t CHAR_NUL   = 8'h00;
    localparam byte_t CHAR_SPACE = 8'h20;
    localparam byte_t CHAR_COLON = 8'h3a;
    localparam byte_t CHAR_CR    = 8'h0d;
    localparam byte_t CHAR_LF    = 8'h0a;
    localparam byte_t CHAR_UC_A  = 8'h41;
    localparam byte_t CHAR_UC_Z  = 8'h5a;
    localparam byte_t CASE_DELTA = 8'h20;

    typedef struct packed {
        phase_t phase;
        count_t counter;
        logic   overflow;
    } parse_state_t;

    typedef struct packed {
        logic   valid;
        kind_t  kind;
        byte_t  data;
        logic   byte_valid;
        logic   field_end;
        count_t index;
        logic   dropped;
    } parse_result_t;

    function automatic byte_t to_lower(input byte_t c);
        byte_t r;
        r = c;
        if (c >= CHAR_UC_A && c <= CHAR_UC_Z)
        begin
            r = c + CASE_DELTA;
        end
        return r;
    endfunction

endpackage

[rtl/core/hrhp_step.sv]
module hrhp_step #(
    parameter int unsigned MAX_HEADERS = 20
) (
    input  hrhp_pkg::parse_state_t  state,
    input  hrhp_pkg::byte_t         data_byte,
    input  logic                    first_byte,
    output hrhp_pkg::parse_state_t  state_next,
    output hrhp_pkg::parse_result_t result
);
    import hrhp_pkg::*;

    localparam count_t MaxHdr = count_t'(MAX_HEADERS);

    parse_state_t eff;
    logic         kept;

    function automatic parse_result_t emit(input kind_t k, input byte_t b,
                                           input logic v, input logic e);
        parse_result_t r;
        r            = '0;
        r.valid      = 1'b1;
        r.kind       = k;
        r.data       = v ? b : CHAR_NUL;
        r.byte_valid = v;
        r.field_end  = e;
        return r;
    endfunction

    always_comb
    begin
        if (first_byte)
        begin
            eff.phase    = PH_METHOD;
            eff.counter  = '0;
            eff.overflow = 1'b0;
        end
        else
        begin
            eff = state;
        end
        kept       = eff.counter < MaxHdr;
        state_next = eff;
        result     = '0;

        if (eff.phase == PH_DONE)
        begin
            state_next.phase = PH_DONE;
        end
        else if (data_byte == CHAR_NUL)
        begin
            state_next.phase = PH_DONE;
            result = emit(KIND_END, CHAR_NUL, 1'b0, 1'b1);
        end
        else
        begin
            unique case (eff.phase)
                PH_METHOD:
                begin
                    if (data_byte == CHAR_SPACE)
                    begin
                        state_next.phase = PH_PATH;
                        result = emit(KIND_METHOD, CHAR_NUL, 1'b0, 1'b1);
                    end
                    else
                    begin
                        result = emit(KIND_METHOD, data_byte, 1'b1, 1'b0);
                    end
                end
                PH_PATH:
                begin
                    if (data_byte == CHAR_SPACE)
                    begin
                        state_next.phase = PH_SKIPLINE;
                        result = emit(KIND_PATH, CHAR_NUL, 1'b0, 1'b1);
                    end
                    else
                    begin
                        result = emit(KIND_PATH, data_byte, 1'b1, 1'b0);
                    end
                end
                PH_SKIPLINE:
                begin
                    if (data_byte == CHAR_LF)
                    begin
                        state_next.phase = PH_LINE;
                    end
                end
                PH_LINE, PH_NAME:
                begin
                    if (eff.phase == PH_LINE && data_byte == CHAR_CR)
                    begin
                        state_next.phase = PH_DONE;
                        result = emit(KIND_END, CHAR_NUL, 1'b0, 1'b1);
                    end
                    else
                    begin
                        if (eff.phase == PH_LINE && !kept)
                        begin
                            state_next.overflow = 1'b1;
                        end
                        if (data_byte == CHAR_COLON)
                        begin
                            state_next.phase = PH_SKIPONE;
                            if (kept)
                            begin
                                result = emit(KIND_NAME, CHAR_NUL, 1'b0, 1'b1);
                            end
                        end
                        else
                        begin
                            state_next.phase = PH_NAME;
                            if (kept)
                            begin
                                result = emit(KIND_NAME, to_lower(data_byte), 1'b1, 1'b0);
                            end
                        end
                    end
                end
                PH_SKIPONE:
                begin
                    state_next.phase = PH_VALUE;
                end
                PH_VALUE:
                begin
                    if (data_byte == CHAR_CR)
                    begin
                        state_next.phase = PH_SKIPLF;
                        if (kept)
                        begin
                            result = emit(KIND_VALUE, CHAR_NUL, 1'b0, 1'b1);
                            state_next.counter = eff.counter + count_t'(1);
                        end
                    end
                    else if (kept)
                    begin
                        result = emit(KIND_VALUE, data_byte, 1'b1, 1'b0);
                    end
                end
                PH_SKIPLF:
                begin
                    state_next.phase = PH_LINE;
                end
                default:
                begin
                    state_next.phase = PH_DONE;
                end
            endcase
        end

        result.index   = eff.counter;
        result.dropped = state_next.overflow;
    end

endmodule

[rtl/core/http_request_head_parser_top.sv]
// HTTP request head parser. One byte of request text is taken per beat and at most one
// tagged result beat comes out for it: method, path, header name (lower-cased), header
// value, or a single end-of-head beat carrying the header count. A new byte is accepted
// every clock while the output side keeps up; each byte passes through the input register,
// then the result register. The rate of one byte per cycle rests on the parse state
// update: state_next is formed combinationally from state_reg and the held byte. At most
// MAX_HEADERS headers are reported; later ones are dropped and headers_dropped is set.
// A byte with first_byte set restarts the parser before that byte is taken.
module http_request_head_parser_top #(
    parameter int unsigned MAX_HEADERS = 20
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  hrhp_pkg::byte_t  data_byte,
    input  logic             first_byte,
    output logic             out_valid,
    input  logic             out_stall,
    output hrhp_pkg::kind_t  field_kind,
    output hrhp_pkg::byte_t  out_byte,
    output logic             byte_valid,
    output logic             field_end,
    output hrhp_pkg::count_t header_index,
    output logic             headers_dropped
);
    import hrhp_pkg::*;

    logic          in_valid_reg;
    byte_t         data_reg;
    logic          first_reg;
    parse_state_t  state_reg;
    parse_state_t  state_next;
    parse_result_t result;
    parse_result_t out_reg;
    logic          advance;

    assign advance  = !out_reg.valid || !out_stall;
    assign in_stall = in_valid_reg && !advance;

    hrhp_step #(
        .MAX_HEADERS(MAX_HEADERS)
    ) u_step (
        .state      (state_reg),
        .data_byte  (data_reg),
        .first_byte (first_reg),
        .state_next (state_next),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            state_reg.phase    <= PH_METHOD;
            state_reg.counter  <= '0;
            state_reg.overflow <= 1'b0;
            out_reg            <= '0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_reg.valid <= in_valid_reg && result.valid;
                if (in_valid_reg)
                begin
                    state_reg <= state_next;
                    if (result.valid)
                    begin
                        out_reg.kind       <= result.kind;
                        out_reg.data       <= result.data;
                        out_reg.byte_valid <= result.byte_valid;
                        out_reg.field_end  <= result.field_end;
                        out_reg.index      <= result.index;
                        out_reg.dropped    <= result.dropped;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            data_reg  <= data_byte;
            first_reg <= first_byte;
        end
    end

    assign out_valid       = out_reg.valid;
    assign field_kind      = out_reg.kind;
    assign out_byte        = out_reg.data;
    assign byte_valid      = out_reg.byte_valid;
    assign field_end       = out_reg.field_end;
    assign header_index    = out_reg.index;
    assign headers_dropped = out_reg.dropped;

endmodule

[rtl/core/hrhp_checker.sv]
module hrhp_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_stall,
    input hrhp_pkg::kind_t  field_kind,
    input hrhp_pkg::byte_t  out_byte,
    input logic             byte_valid,
    input logic             field_end,
    input hrhp_pkg::count_t header_index,
    input logic             headers_dropped
);
    import hrhp_pkg::*;

    // stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(field_kind) && $stable(out_byte)
            && $stable(byte_valid) && $stable(field_end) && $stable(header_index)
            && $stable(headers_dropped))
        else $error("stalled result beat changed");

    a_delim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> out_byte == CHAR_NUL && field_end)
        else $error("delimiter beat with content");

    a_end_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && field_kind == KIND_END |-> field_end && !byte_valid)
        else $error("end of head beat malformed");

    a_content_open: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_valid |-> !field_end && field_kind != KIND_END)
        else $error("content beat marked as field end");

    a_name_lower: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_valid && field_kind == KIND_NAME
            |-> !(out_byte >= CHAR_UC_A && out_byte <= CHAR_UC_Z))
        else $error("header name byte not lower-cased");

endmodule

bind http_request_head_parser_top hrhp_checker u_hrhp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .field_kind      (field_kind),
    .out_byte        (out_byte),
    .byte_valid      (byte_valid),
    .field_end       (field_end),
    .header_index    (header_index),
    .headers_dropped (headers_dropped)
);
